@@ src/ipv4_cidr_range_filter_assert.svh @@
// Assertion macros for the IPv4 CIDR range filter.
`ifndef IPV4_CIDR_RANGE_FILTER_ASSERT_SVH
`define IPV4_CIDR_RANGE_FILTER_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, sampled on clk and disabled while rst is high.
`define ICRF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on clk and disabled while rst is high.
`define ICRF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ICRF_ASSERT_IMP(lbl, ante, cons, msg)
`define ICRF_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

@@ src/icrf_pkg.sv @@
// Shared types, constants and helper functions of the IPv4 CIDR range filter.
`timescale 1ns / 1ps
`default_nettype none
package icrf_pkg;

  localparam int LIST_DEPTH_DEF = 16;
  localparam int ADDR_W         = 32;
  localparam int PLEN_W         = 6;
  localparam int HOST_PLEN      = 32;

  localparam logic [ADDR_W-1:0] ALL_ONES = {ADDR_W{1'b1}};

  localparam logic OP_ADD     = 1'b0;
  localparam logic OP_CHECK   = 1'b1;
  localparam logic LIST_BLOCK = 1'b0;
  localparam logic LIST_ALLOW = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;         // capture the incoming word, clear the scan
    logic add_write;    // store the captured range if the list has room
    logic scan_rd;      // read the entry under the scan index, advance it
    logic result_load;  // move the finished result into the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_check;     // captured word is an address check
    logic list_empty;   // both lists hold no ranges
    logic scan_last;    // scan index points at the last used entry
  } dp_stat_t;

  // Network mask with plen leading ones; lengths above 32 act as a host route.
  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] plen);
    logic [ADDR_W-1:0] mask;
    if (plen >= PLEN_W'(HOST_PLEN)) begin
      mask = ALL_ONES;
    end else begin
      mask = ~(ALL_ONES >> plen);
    end
    return mask;
  endfunction

endpackage
`default_nettype wire

@@ src/icrf_if.sv @@
// Request and response channel interfaces of the IPv4 CIDR range filter.
`timescale 1ns / 1ps
`default_nettype none
interface icrf_req_if
  import icrf_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              operation;
  logic              list_select;
  logic [ADDR_W-1:0] address;
  logic [PLEN_W-1:0] prefix_len;

  modport source (output valid, output operation, output list_select,
                  output address, output prefix_len, input ready);
  modport sink   (input valid, input operation, input list_select,
                  input address, input prefix_len, output ready);
endinterface

interface icrf_rsp_if;
  logic valid;
  logic ready;
  logic status;
  logic in_block_list;
  logic in_allow_list;

  modport source (output valid, output status, output in_block_list,
                  output in_allow_list, input ready);
  modport sink   (input valid, input status, input in_block_list,
                  input in_allow_list, output ready);
endinterface
`default_nettype wire

@@ src/icrf_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module icrf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ src/icrf_ctrl.sv @@
// Controller state machine and handshake logic of the IPv4 CIDR range filter.
`timescale 1ns / 1ps
`default_nettype none
module icrf_ctrl
  import icrf_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  input  wire logic      rsp_ready,
  input  wire dp_stat_t  stat,
  output logic           req_ready,
  output logic           rsp_valid,
  output ctrl_cmd_t      cmd
);

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.result_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!stat.is_check || stat.list_empty) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    req_ready       = 1'b0;
    cmd             = '0;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        cmd.load  = req_valid;
      end
      ST_DECIDE: begin
        cmd.add_write = !stat.is_check;
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
      end
      ST_FINISH: begin
        cmd.result_load = out_free;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ src/icrf_dp.sv @@
// Datapath of the IPv4 CIDR range filter: item capture, range tables, scan and result.
`timescale 1ns / 1ps
`default_nettype none
module icrf_dp
  import icrf_pkg::*;
#(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ctrl_cmd_t         cmd,
  input  wire logic              operation,
  input  wire logic              list_select,
  input  wire logic [ADDR_W-1:0] address,
  input  wire logic [PLEN_W-1:0] prefix_len,
  output dp_stat_t               stat,
  output logic                   status,
  output logic                   in_block_list,
  output logic                   in_allow_list
);

  localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int ENT_W = 2 * ADDR_W;

  // Captured item.
  logic              item_op;
  logic              item_sel;
  logic [ADDR_W-1:0] item_addr;
  logic [PLEN_W-1:0] item_plen;

  logic [CNT_W-1:0]  block_used;
  logic [CNT_W-1:0]  allow_used;
  logic [CNT_W-1:0]  scan_idx;
  logic [CNT_W-1:0]  max_used;
  logic              pend_blk;
  logic              pend_alw;
  logic              blk_hit;
  logic              alw_hit;
  logic              add_full;

  logic [ADDR_W-1:0] mask;
  logic [ENT_W-1:0]  wdata;
  logic              sel_full;
  logic              we_blk;
  logic              we_alw;
  logic [IDX_W-1:0]  waddr;
  logic [ENT_W-1:0]  blk_ent;
  logic [ENT_W-1:0]  alw_ent;
  logic              blk_match;
  logic              alw_match;

  assign mask     = prefix_mask(item_plen);
  assign wdata    = {item_addr & mask, item_addr | ~mask};
  assign sel_full = (item_sel == LIST_ALLOW) ? (allow_used == CNT_W'(LIST_DEPTH))
                                             : (block_used == CNT_W'(LIST_DEPTH));
  assign we_blk   = cmd.add_write && (item_sel == LIST_BLOCK) && !sel_full;
  assign we_alw   = cmd.add_write && (item_sel == LIST_ALLOW) && !sel_full;
  assign waddr    = (item_sel == LIST_ALLOW) ? allow_used[IDX_W-1:0]
                                             : block_used[IDX_W-1:0];
  assign max_used = (block_used > allow_used) ? block_used : allow_used;

  assign stat.is_check   = (item_op == OP_CHECK);
  assign stat.list_empty = (max_used == '0);
  assign stat.scan_last  = (scan_idx == max_used - CNT_W'(1));

  icrf_ram #(.WIDTH(ENT_W), .DEPTH(LIST_DEPTH)) u_block_ram (
    .clk   (clk),
    .we    (we_blk),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (scan_idx[IDX_W-1:0]),
    .rdata (blk_ent)
  );

  icrf_ram #(.WIDTH(ENT_W), .DEPTH(LIST_DEPTH)) u_allow_ram (
    .clk   (clk),
    .we    (we_alw),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (scan_idx[IDX_W-1:0]),
    .rdata (alw_ent)
  );

  // Entries hold the low bound in the upper half and the high bound below it.
  assign blk_match = pend_blk && (item_addr >= blk_ent[ENT_W-1:ADDR_W])
                              && (item_addr <= blk_ent[ADDR_W-1:0]);
  assign alw_match = pend_alw && (item_addr >= alw_ent[ENT_W-1:ADDR_W])
                              && (item_addr <= alw_ent[ADDR_W-1:0]);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_op   <= operation;
      item_sel  <= list_select;
      item_addr <= address;
      item_plen <= prefix_len;
    end
    if (cmd.add_write) begin
      add_full <= sel_full;
    end
    if (cmd.result_load) begin
      status        <= (item_op == OP_ADD) && add_full;
      in_block_list <= (item_op == OP_CHECK) && blk_hit;
      in_allow_list <= (item_op == OP_CHECK) && ((allow_used == '0) || alw_hit);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_used <= '0;
      allow_used <= '0;
      scan_idx   <= '0;
      pend_blk   <= 1'b0;
      pend_alw   <= 1'b0;
      blk_hit    <= 1'b0;
      alw_hit    <= 1'b0;
    end else begin
      if (we_blk) begin
        block_used <= block_used + CNT_W'(1);
      end
      if (we_alw) begin
        allow_used <= allow_used + CNT_W'(1);
      end
      pend_blk <= cmd.scan_rd && (scan_idx < block_used);
      pend_alw <= cmd.scan_rd && (scan_idx < allow_used);
      if (cmd.load) begin
        scan_idx <= '0;
        blk_hit  <= 1'b0;
        alw_hit  <= 1'b0;
      end else begin
        if (cmd.scan_rd) begin
          scan_idx <= scan_idx + CNT_W'(1);
        end
        blk_hit <= blk_hit || blk_match;
        alw_hit <= alw_hit || alw_match;
      end
    end
  end

endmodule
`default_nettype wire

@@ src/ipv4_cidr_range_filter.sv @@
// Top level of the IPv4 CIDR range filter: controller, datapath and checks.
`timescale 1ns / 1ps
`default_nettype none
`include "ipv4_cidr_range_filter_assert.svh"
// The filter keeps a block list and an allow list of IPv4 ranges, each up to
// LIST_DEPTH entries held in its own RAM. An add word (operation 0) turns the
// address and prefix length into the range from address AND mask to address
// OR NOT mask and appends it to the list picked by list_select; a prefix above
// 32 stores a single host. An add to a full list is dropped and answered with
// status 1. A check word (operation 1) answers whether the address falls in
// any block-list range and in any allow-list range; an empty allow list
// allows every address. Every word gives exactly one response word. The block
// works on one word at a time. A check walks both lists side by side, up to
// the larger of the two counts, at one entry per cycle through the single
// read port of each RAM; with both lists empty no walk is done. A finished
// response sits in an output register, so the next word is taken while the
// previous response still waits; the block only holds off at the end of a
// word when that register has not yet been emptied. Stored ranges need no
// clearing after reset; only entries below each list's count are ever used.
module ipv4_cidr_range_filter
  import icrf_pkg::*;
#(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input wire logic  clk,
  input wire logic  rst,
  icrf_req_if.sink  req,
  icrf_rsp_if.source rsp
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // The controller owns both handshakes and the response valid flag.
  icrf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .cmd       (cmd)
  );

  // The datapath holds the range tables, the scan and the response payload.
  icrf_dp #(.LIST_DEPTH(LIST_DEPTH)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .operation     (req.operation),
    .list_select   (req.list_select),
    .address       (req.address),
    .prefix_len    (req.prefix_len),
    .stat          (stat),
    .status        (rsp.status),
    .in_block_list (rsp.in_block_list),
    .in_allow_list (rsp.in_allow_list)
  );

  // One word in flight: after a word is taken the input stays closed.
  `ICRF_ASSERT_NXT(a_one_in_flight, req.valid && req.ready, !req.ready, "word taken while busy")
  // A response never overwrites one that has not been delivered.
  `ICRF_ASSERT_IMP(a_no_overwrite, cmd.result_load, !rsp.valid || rsp.ready, "response lost")
  // Table writes come only from add words.
  `ICRF_ASSERT_IMP(a_add_only, cmd.add_write, !stat.is_check, "table write on a check")
  // The scan runs only for a check with at least one stored range.
  `ICRF_ASSERT_IMP(a_scan_check, cmd.scan_rd, stat.is_check && !stat.list_empty, "bad scan")

endmodule
`default_nettype wire
